// ----- hw/rtl/rdc_pkg.sv -----
// Shared constants for the Rabin CRT decryption block.
package rdc_pkg;
  localparam int PRIME_BITS_DEF = 16;
  localparam int CIPHER_BITS    = 32;
  localparam int CFG_DATA_BITS  = 16;
  localparam int KEEP_LIMIT     = 127;
  localparam int RESET_P        = 7;
  localparam int RESET_Q        = 11;
  localparam logic [1:0] CFG_P  = 2'd0;
  localparam logic [1:0] CFG_Q  = 2'd1;
endpackage

// ----- hw/rtl/rdc_mulmod.sv -----
// Bit-serial modular multiplier: res = (x * y) mod m, one multiplier bit per cycle.
module rdc_mulmod #(
  parameter int W  = 32,
  parameter int YW = 32,
  parameter int LW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [W-1:0]  x,
  input  logic [YW-1:0] y,
  input  logic [W-1:0]  m,
  input  logic [LW-1:0] len,
  output logic          done,
  output logic [W-1:0]  res
);
  logic          run;
  logic [LW-1:0] cnt;
  logic [YW-1:0] ysh;
  logic [W-1:0]  xr;
  logic [W-1:0]  mr;
  logic [W-1:0]  r;
  logic [W:0]    dbl;
  logic [W-1:0]  dred;
  logic [W:0]    sum;
  logic [W-1:0]  r_next;

  always_comb begin
    dbl  = {r, 1'b0};
    dred = (dbl >= {1'b0, mr}) ? W'(dbl - {1'b0, mr}) : W'(dbl);
    sum  = {1'b0, dred} + {1'b0, xr};
    if (ysh[YW-1]) begin
      r_next = (sum >= {1'b0, mr}) ? W'(sum - {1'b0, mr}) : W'(sum);
    end else begin
      r_next = dred;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        r   <= '0;
        xr  <= x;
        mr  <= m;
        ysh <= y << (LW'(YW) - len);
        cnt <= len;
        if (len == '0) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        r   <= r_next;
        ysh <= ysh << 1;
        cnt <= cnt - LW'(1);
        if (cnt == LW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = r;
endmodule

// ----- hw/rtl/rabin_decrypt_crt.sv -----
// Rabin decryption top level: sequencer around one shared modular multiplier.
//
// Usage: load prime_p (index 0) and prime_q (index 1) through cfg_we/cfg_addr/
// cfg_data while the block is idle; reset loads p = 7 and q = 11.
// An item (cipher_value) is taken at a clock edge with start high and busy
// low. busy drops in the cycle the result is shown. The four CRT roots and the
// four keep flags appear for exactly one cycle with done high; the receiver
// cannot stall, so the block is already idle while done is high.
// Exponentiations and CRT products run through one bit-serial modular
// multiplier, one multiplier bit per cycle; the two weights and n come from a
// small PRIME_BITS x PRIME_BITS product. An item runs four exponentiations
// (weights for p and q, square roots mod p and mod q). Each one first reduces
// its base (the ciphertext for the square roots), then for each exponent bit
// multiplies when the bit is set and squares. Then come three weight/modulus
// products, four CRT products and four sums. The exponent loop ends when no
// exponent bits are left, so small primes give a much shorter run.
// With a zero prime the sequencer goes straight to its final state and shows
// an all-zero result.
// Synchronous active-high reset returns the sequencer to idle.
module rabin_decrypt_crt
  import rdc_pkg::*;
#(
  parameter int PRIME_BITS = rdc_pkg::PRIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [rdc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               start,
  input  logic [rdc_pkg::CIPHER_BITS-1:0]    cipher_value,
  output logic                               busy,
  output logic                               done,
  output logic [31:0]                        root_one,
  output logic [31:0]                        root_two,
  output logic [31:0]                        root_three,
  output logic [31:0]                        root_four,
  output logic                               keep_one,
  output logic                               keep_two,
  output logic                               keep_three,
  output logic                               keep_four
);
  localparam int PB = PRIME_BITS;
  localparam int W  = 2 * PB;
  localparam int YW = (W > CIPHER_BITS) ? W : CIPHER_BITS;
  localparam int LW = $clog2(YW + 1);
  localparam int CW = (PB < CFG_DATA_BITS) ? PB : CFG_DATA_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_REDW   = 4'd2;
  localparam logic [3:0] S_LOOP   = 4'd3;
  localparam logic [3:0] S_MULW   = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_SQW    = 4'd6;
  localparam logic [3:0] S_PEND   = 4'd7;
  localparam logic [3:0] S_WA     = 4'd8;
  localparam logic [3:0] S_WB     = 4'd9;
  localparam logic [3:0] S_WN     = 4'd10;
  localparam logic [3:0] S_WRED   = 4'd11;
  localparam logic [3:0] S_PROD   = 4'd12;
  localparam logic [3:0] S_PRODW  = 4'd13;
  localparam logic [3:0] S_SUM    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0]             state;
  logic [PB-1:0]          prime_p;
  logic [PB-1:0]          prime_q;
  logic [CIPHER_BITS-1:0] c_reg;
  logic                   zflag;
  logic [1:0]             phase;
  logic [1:0]             pidx;
  logic [PB-1:0]          e;
  logic [PB-1:0]          pr;
  logic [PB-1:0]          px;
  logic [PB-1:0]          sa;
  logic [PB-1:0]          sb;
  logic [PB-1:0]          m1;
  logic [PB-1:0]          m3;
  logic [W-1:0]           wa;
  logic [W-1:0]           wb;
  logic [W-1:0]           nn;
  logic [W-1:0]           pa3;
  logic [W-1:0]           pa4;
  logic [W-1:0]           pb1;
  logic [W-1:0]           pb2;
  logic [W-1:0]           rt0;
  logic [W-1:0]           rt1;
  logic [W-1:0]           rt2;
  logic [W-1:0]           rt3;

  logic [PB-1:0]          mod_sel;
  logic [YW-1:0]          base_sel;
  logic [LW-1:0]          len_sel;
  logic [PB-1:0]          exp_sel;
  logic [PB-1:0]          one_sel;
  logic [PB:0]            p_inc;
  logic [PB:0]            q_inc;
  logic [PB-1:0]          m1n;
  logic [PB-1:0]          m2n;
  logic [PB-1:0]          m3n;
  logic [PB-1:0]          m4n;
  logic [PB-1:0]          m2d;
  logic [PB-1:0]          m4d;
  logic [W-1:0]           msel;
  logic [W-1:0]           mul_a;
  logic [W-1:0]           mul_b;
  logic [W-1:0]           mul_out;
  logic [W-1:0]           ta;
  logic [W-1:0]           tb;
  logic [W:0]             rsum;
  logic [W-1:0]           rmod;
  logic [W-1:0]           rnz;

  logic                   mm_go;
  logic [W-1:0]           mm_x;
  logic [YW-1:0]          mm_y;
  logic [W-1:0]           mm_m;
  logic [LW-1:0]          mm_len;
  logic                   mm_done;
  logic [W-1:0]           mm_res;

  rdc_mulmod #(.W(W), .YW(YW), .LW(LW)) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .x    (mm_x),
    .y    (mm_y),
    .m    (mm_m),
    .len  (mm_len),
    .done (mm_done),
    .res  (mm_res)
  );

  // Per-phase operands: 0 = p^(q-2) mod q, 1 = q^(p-2) mod p, 2 = c^((p+1)/4) mod p,
  // 3 = c^((q+1)/4) mod q.
  always_comb begin
    p_inc = {1'b0, prime_p} + (PB+1)'(1);
    q_inc = {1'b0, prime_q} + (PB+1)'(1);
    unique case (phase)
      2'd0: begin
        mod_sel  = prime_q;
        base_sel = YW'(prime_p);
        len_sel  = LW'(PB);
        exp_sel  = (prime_q >= PB'(2)) ? prime_q - PB'(2) : '0;
      end
      2'd1: begin
        mod_sel  = prime_p;
        base_sel = YW'(prime_q);
        len_sel  = LW'(PB);
        exp_sel  = (prime_p >= PB'(2)) ? prime_p - PB'(2) : '0;
      end
      2'd2: begin
        mod_sel  = prime_p;
        base_sel = YW'(c_reg);
        len_sel  = LW'(CIPHER_BITS);
        exp_sel  = PB'(p_inc >> 2);
      end
      default: begin
        mod_sel  = prime_q;
        base_sel = YW'(c_reg);
        len_sel  = LW'(CIPHER_BITS);
        exp_sel  = PB'(q_inc >> 2);
      end
    endcase
    one_sel = (mod_sel == PB'(1)) ? '0 : PB'(1);
  end

  always_comb begin
    m1n = (m1 == '0) ? prime_p : m1;
    m2d = prime_p - m1n;
    m2n = (m2d == '0) ? prime_p : m2d;
    m3n = (m3 == '0) ? prime_q : m3;
    m4d = prime_q - m3n;
    m4n = (m4d == '0) ? prime_q : m4d;
    unique case (pidx)
      2'd0:    msel = W'(m3n);
      2'd1:    msel = W'(m4n);
      2'd2:    msel = W'(m1n);
      default: msel = W'(m2n);
    endcase
    if (msel == nn) begin
      msel = '0;
    end
  end

  always_comb begin
    unique case (state)
      S_WA: begin
        mul_a = W'((sa == '0) ? prime_q : sa);
        mul_b = W'(prime_p);
      end
      S_WB: begin
        mul_a = W'((sb == '0) ? prime_p : sb);
        mul_b = W'(prime_q);
      end
      default: begin
        mul_a = W'(prime_p);
        mul_b = W'(prime_q);
      end
    endcase
    mul_out = W'(mul_a[PB-1:0]) * W'(mul_b[PB-1:0]);
  end

  always_comb begin
    ta   = pidx[0] ? pa4 : pa3;
    tb   = pidx[1] ? pb2 : pb1;
    rsum = {1'b0, ta} + {1'b0, tb};
    rmod = (rsum >= {1'b0, nn}) ? W'(rsum - {1'b0, nn}) : W'(rsum);
    rnz  = (rmod == '0) ? nn : rmod;
  end

  always_comb begin
    mm_go  = 1'b0;
    mm_x   = '0;
    mm_y   = '0;
    mm_m   = W'(mod_sel);
    mm_len = LW'(PB);
    unique case (state)
      S_RED: begin
        mm_go  = 1'b1;
        mm_x   = W'(one_sel);
        mm_y   = base_sel;
        mm_len = len_sel;
      end
      S_LOOP: begin
        mm_go = (e != '0) && e[0];
        mm_x  = W'(pr);
        mm_y  = YW'(px);
      end
      S_SQ: begin
        mm_go = 1'b1;
        mm_x  = W'(px);
        mm_y  = YW'(px);
      end
      S_PROD: begin
        mm_go = 1'b1;
        mm_x  = pidx[1] ? wb : wa;
        mm_y  = YW'(msel);
        mm_m  = nn;
      end
      default: begin
        mm_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p <= PB'(RESET_P);
      prime_q <= PB'(RESET_Q);
    end else if (cfg_we) begin
      if (cfg_addr == CFG_P) begin
        prime_p <= PB'(cfg_data[CW-1:0]);
      end else if (cfg_addr == CFG_Q) begin
        prime_q <= PB'(cfg_data[CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            c_reg <= cipher_value;
            phase <= 2'd0;
            if (prime_p == '0 || prime_q == '0) begin
              zflag <= 1'b1;
              rt0   <= '0;
              rt1   <= '0;
              rt2   <= '0;
              rt3   <= '0;
              state <= S_FIN;
            end else begin
              zflag <= 1'b0;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          e     <= exp_sel;
          pr    <= one_sel;
          state <= S_REDW;
        end
        S_REDW: begin
          if (mm_done) begin
            px    <= PB'(mm_res);
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (e == '0) begin
            state <= S_PEND;
          end else if (e[0]) begin
            state <= S_MULW;
          end else begin
            state <= S_SQ;
          end
        end
        S_MULW: begin
          if (mm_done) begin
            pr    <= PB'(mm_res);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          if (mm_done) begin
            px    <= PB'(mm_res);
            e     <= e >> 1;
            state <= S_LOOP;
          end
        end
        S_PEND: begin
          unique case (phase)
            2'd0:    sa <= pr;
            2'd1:    sb <= pr;
            2'd2:    m1 <= pr;
            default: m3 <= pr;
          endcase
          if (phase == 2'd3) begin
            state <= S_WA;
          end else begin
            phase <= phase + 2'd1;
            state <= S_RED;
          end
        end
        S_WA: begin
          wa    <= mul_out;
          state <= S_WB;
        end
        S_WB: begin
          wb    <= mul_out;
          state <= S_WN;
        end
        S_WN: begin
          nn    <= mul_out;
          state <= S_WRED;
        end
        S_WRED: begin
          if (wa == nn) begin
            wa <= '0;
          end
          if (wb == nn) begin
            wb <= '0;
          end
          pidx  <= 2'd0;
          state <= S_PROD;
        end
        S_PROD: begin
          state <= S_PRODW;
        end
        S_PRODW: begin
          if (mm_done) begin
            unique case (pidx)
              2'd0:    pa3 <= mm_res;
              2'd1:    pa4 <= mm_res;
              2'd2:    pb1 <= mm_res;
              default: pb2 <= mm_res;
            endcase
            pidx <= pidx + 2'd1;
            if (pidx == 2'd3) begin
              state <= S_SUM;
            end else begin
              state <= S_PROD;
            end
          end
        end
        S_SUM: begin
          unique case (pidx)
            2'd0:    rt0 <= rnz;
            2'd1:    rt1 <= rnz;
            2'd2:    rt2 <= rnz;
            default: rt3 <= rnz;
          endcase
          pidx <= pidx + 2'd1;
          if (pidx == 2'd3) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          root_one   <= 32'(rt0);
          root_two   <= 32'(rt1);
          root_three <= 32'(rt2);
          root_four  <= 32'(rt3);
          keep_one   <= !zflag && (rt0 < W'(KEEP_LIMIT));
          keep_two   <= !zflag && (rt1 < W'(KEEP_LIMIT)) && (rt1 != rt0);
          keep_three <= !zflag && (rt2 < W'(KEEP_LIMIT)) && (rt2 != rt1) && (rt2 != rt0);
          keep_four  <= !zflag && (rt3 < W'(KEEP_LIMIT)) && (rt3 != rt2) && (rt3 != rt1)
                        && (rt3 != rt0);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
endmodule

// ----- tb/rabin_decrypt_crt_test.sv -----
// Testbench for rabin_decrypt_crt: directed and random ciphertexts against a root predictor.
`timescale 1ns / 100ps

module rabin_decrypt_crt_test;
  import rdc_pkg::*;

  typedef struct packed {
    logic [31:0] r1, r2, r3, r4;
    logic        k1, k2, k3, k4;
  } roots_t;

  typedef struct {
    logic [31:0] c;
    logic        known;
    roots_t      res;
  } vec_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = CFG_P;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic start = 0;
  logic [31:0] cipher_value = '0;
  logic busy, done;
  logic [31:0] root_one, root_two, root_three, root_four;
  logic keep_one, keep_two, keep_three, keep_four;

  logic [63:0] prime_p = RESET_P, prime_q = RESET_Q;
  roots_t expected_roots[$];
  int errors = 0;
  int items_sent = 0;

  rabin_decrypt_crt dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] t;
    t = x * y;
    return t % m;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] r, x;
    r = 1 % m;
    x = base % m;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, x, m);
      x = mulmod(x, x, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] nz(logic [63:0] v, logic [63:0] m);
    return (v == 0) ? m : v;
  endfunction

  function automatic roots_t decrypt_roots(logic [31:0] c);
    logic [63:0] n, a, b, m1, m2, m3, m4;
    logic [63:0] r[4];
    roots_t o;
    o = '0;
    if (prime_p == 0 || prime_q == 0) return o;
    n = prime_p * prime_q;
    a = nz(powmod(prime_p, (prime_q >= 2) ? prime_q - 2 : 0, prime_q), prime_q) * prime_p;
    b = nz(powmod(prime_q, (prime_p >= 2) ? prime_p - 2 : 0, prime_p), prime_p) * prime_q;
    m1 = nz(powmod(c, (prime_p + 1) / 4, prime_p), prime_p);
    m2 = nz((prime_p - m1) % prime_p, prime_p);
    m3 = nz(powmod(c, (prime_q + 1) / 4, prime_q), prime_q);
    m4 = nz((prime_q - m3) % prime_q, prime_q);
    r[0] = nz((mulmod(a % n, m3 % n, n) + mulmod(b % n, m1 % n, n)) % n, n);
    r[1] = nz((mulmod(a % n, m4 % n, n) + mulmod(b % n, m1 % n, n)) % n, n);
    r[2] = nz((mulmod(a % n, m3 % n, n) + mulmod(b % n, m2 % n, n)) % n, n);
    r[3] = nz((mulmod(a % n, m4 % n, n) + mulmod(b % n, m2 % n, n)) % n, n);
    o.r1 = r[0][31:0];
    o.r2 = r[1][31:0];
    o.r3 = r[2][31:0];
    o.r4 = r[3][31:0];
    o.k1 = r[0] < KEEP_LIMIT;
    o.k2 = r[1] < KEEP_LIMIT && r[1] != r[0];
    o.k3 = r[2] < KEEP_LIMIT && r[2] != r[1] && r[2] != r[0];
    o.k4 = r[3] < KEEP_LIMIT && r[3] != r[2] && r[3] != r[1] && r[3] != r[0];
    return o;
  endfunction

  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && done) begin
      got = {root_one, root_two, root_three, root_four,
             keep_one, keep_two, keep_three, keep_four};
      if (expected_roots.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_roots.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_cipher(logic [31:0] c, bit known, roots_t res, bit gaps);
    @(posedge clk);
    if (gaps) idle_gap();
    start <= 1;
    cipher_value <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_roots.push_back(known ? res : decrypt_roots(c));
    items_sent++;
    start <= 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_P) prime_p = 64'(val);
    else if (idx == CFG_Q) prime_q = 64'(val);
  endtask

  // primes congruent to 3 mod 4, the prime 65521 (1 mod 4), plus odd and degenerate values
  logic [15:0] p_set[12] = '{7, 3, 65519, 19, 43, 1, 9, 2, 65535, 4, 11, 23};
  logic [15:0] q_set[12] = '{11, 65521, 3, 65479, 31, 15, 1, 65535, 2, 0, 7, 47};

  initial begin
    vec_t vecs[$];
    roots_t z;
    z = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset primes 7 and 11: c=4 gives roots 2,9,68,75 (n=77)
    vecs.push_back('{32'd4, 1, '{32'd9, 32'd2, 32'd75, 32'd68, 1'b1, 1'b1, 1'b1, 1'b1}});
    vecs.push_back('{32'd0, 0, z});
    vecs.push_back('{32'd1, 0, z});
    vecs.push_back('{32'd77, 0, z});
    vecs.push_back('{32'd76, 0, z});
    vecs.push_back('{32'hFFFF_FFFF, 0, z});
    vecs.push_back('{32'h8000_0000, 0, z});
    vecs.push_back('{32'h5555_5555, 0, z});
    vecs.push_back('{32'hAAAA_AAAA, 0, z});
    foreach (vecs[i]) send_cipher(vecs[i].c, vecs[i].known, vecs[i].res, 0);
    write_reg(CFG_P, 16'd0);
    send_cipher(32'd5, 1, z, 0);
    write_reg(2'd2, 16'd123);
    write_reg(2'd3, 16'd99);
    send_cipher(32'd9, 1, z, 0);
    write_reg(CFG_P, 16'd65519);
    write_reg(CFG_Q, 16'd65521);
    send_cipher(32'hFFFF_FFFF, 0, z, 0);
    send_cipher(32'd0, 0, z, 0);
    send_cipher(32'd65519 * 32'd65521, 0, z, 0);
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_P, p_set[ph]);
      write_reg(CFG_Q, q_set[ph]);
      for (int i = 0; i < 23; i++) begin
        logic [31:0] c;
        logic [63:0] n;
        n = prime_p * prime_q;
        case ($urandom_range(0, 3))
          0: c = $urandom();
          1: c = (n != 0) ? ($urandom() % n) + 1 : $urandom();
          2: c = (n != 0) ? ((($urandom() % 11) + 1) ** 2) % n : $urandom_range(0, 200);
          default: c = $urandom_range(0, 255);
        endcase
        send_cipher(c, 0, z, 1);
      end
    end
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("rabin_decrypt_crt test passed");
    end else begin
      $display("rabin_decrypt_crt test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("rabin_decrypt_crt test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_mulmod.sv
hw/rtl/rabin_decrypt_crt.sv
tb/rabin_decrypt_crt_test.sv
